// ----- sv/spdc_pkg.sv -----
// Shared types, constants and CRC function for the status packet deframer.
`default_nettype none

package spdc_pkg;

  localparam int MAX_PACKET = 1024;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ID  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 2'd1;

  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_TIMEOUT = 1'b1;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_CRC_BAD   = 2'd1;
  localparam logic [1:0] STAT_TMO_EMPTY = 2'd2;
  localparam logic [1:0] STAT_TMO_PART  = 2'd3;

  localparam logic [7:0]  HDR_FF       = 8'hFF;
  localparam logic [7:0]  HDR_FD       = 8'hFD;
  localparam logic [7:0]  RSVD_OK      = 8'h00;
  localparam logic [7:0]  INSTR_STATUS = 8'h55;
  localparam logic [15:0] CRC_POLY     = 16'h8005;
  localparam logic [15:0] MIN_LENGTH   = 16'd4;

  localparam logic [10:0] LEN_TO_TOTAL  = 11'd7;
  localparam logic [10:0] BODY_START    = 11'd8;
  localparam logic [10:0] TOTAL_RESET   = 11'd11;
  localparam logic [10:0] MAX_LEN_RESET = 11'd1024;
  localparam logic [7:0]  TARGET_RESET  = 8'd1;
  localparam logic [3:0]  WIN_DEPTH     = 4'd8;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } spdc_in_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
    logic [1:0] status;
    logic [7:0] servo_id;
    logic [7:0] error_code;
  } spdc_out_t;

  typedef struct packed {
    logic load;
    logic exec_timeout;
    logic exec_hunt;
    logic exec_body;
    logic drop;
    logic hdr_start;
    logic hdr_crc;
  } spdc_cmd_t;

  typedef struct packed {
    logic is_timeout;
    logic phase_body;
    logic body_needs_out;
    logic out_free;
    logic scan_drop;
    logic scan_accept;
    logic hdr_last;
  } spdc_sts_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- sv/spdc_ctrl.sv -----
// Controller state machine sequencing request execution, header scan and header CRC.
`default_nettype none

module spdc_ctrl
  import spdc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      accept,
  input  wire spdc_sts_t sts,
  output spdc_cmd_t      cmd,
  output logic           in_stall
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN, S_HCRC} state_t;

  state_t state_r, state_nxt;
  logic   stall_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.is_timeout) begin
          if (sts.out_free) begin
            cmd.exec_timeout = 1'b1;
            state_nxt        = S_IDLE;
          end
        end else if (!sts.phase_body) begin
          cmd.exec_hunt = 1'b1;
          state_nxt     = S_SCAN;
        end else if (!sts.body_needs_out || sts.out_free) begin
          cmd.exec_body = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts.scan_drop) begin
          cmd.drop = 1'b1;
        end else if (sts.scan_accept) begin
          cmd.hdr_start = 1'b1;
          state_nxt     = S_HCRC;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_HCRC: begin
        cmd.hdr_crc = 1'b1;
        if (sts.hdr_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      stall_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      stall_r <= (state_nxt != S_IDLE);
    end
  end

  assign in_stall = stall_r;

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> state_r == S_IDLE) else $error("request accepted while busy");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_EXEC) else $error("accepted request not executed");

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.exec_timeout, cmd.exec_hunt, cmd.exec_body,
              cmd.drop, cmd.hdr_start, cmd.hdr_crc}))
    else $error("conflicting datapath commands");

  a_hcrc_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_HCRC && sts.hdr_last |=> state_r == S_IDLE)
    else $error("header CRC pass overran");

endmodule

`default_nettype wire

// ----- sv/spdc_dp.sv -----
// Datapath: header window, packet counters, CRC accumulator, config and result registers.
`default_nettype none

module spdc_dp
  import spdc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire spdc_cmd_t             cmd,
  output spdc_sts_t                  sts,
  input  wire spdc_in_t              in_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output spdc_out_t                  out_data
);

  spdc_in_t    item_r;
  logic [7:0]  target_id_r;
  logic [10:0] max_len_r;
  logic        phase_r;
  logic [7:0]  win_r [WIN_DEPTH];
  logic [3:0]  fill_r;
  logic [10:0] count_r;
  logic [10:0] total_r;
  logic [15:0] crc_r;
  logic [7:0]  crc_low_r;
  logic [7:0]  pkt_id_r;
  logic [7:0]  pkt_err_r;
  logic        seen_r;
  logic [2:0]  hidx_r;
  logic        out_valid_r;
  spdc_out_t   out_data_r;

  logic [15:0] len16;
  logic        hdr_bad;
  logic        mine;
  logic        body_end;
  logic        body_crcfield;
  logic        out_free;
  logic        res_load;
  logic [2:0]  wr_idx;
  logic [15:0] crc_item;
  spdc_out_t   tmo_res;
  spdc_out_t   body_res;

  assign len16   = {win_r[6], win_r[5]};
  assign hdr_bad = (win_r[3] != RSVD_OK) || (len16 < MIN_LENGTH) ||
                   (len16 > {5'd0, max_len_r}) || (len16 > 16'(MAX_PACKET)) ||
                   (win_r[7] != INSTR_STATUS);

  assign mine          = (pkt_id_r == target_id_r);
  assign body_end      = ({1'b0, count_r} + 12'd1) >= {1'b0, total_r};
  assign body_crcfield = ({1'b0, count_r} + 12'd2) == {1'b0, total_r};
  assign out_free      = !out_valid_r || !out_stall;
  assign res_load      = cmd.exec_timeout || (cmd.exec_body && sts.body_needs_out);
  assign wr_idx        = (fill_r > 4'd7) ? 3'd7 : fill_r[2:0];
  assign crc_item      = crc_byte(crc_r, item_r.rx_byte);

  always_comb begin
    sts                = '0;
    sts.is_timeout     = (item_r.cmd == CMD_TIMEOUT);
    sts.phase_body     = phase_r;
    sts.out_free       = out_free;
    sts.body_needs_out = mine && (body_end || (!body_crcfield && count_r != BODY_START));
    sts.scan_drop      = (fill_r >= 4'd1 && win_r[0] != HDR_FF) ||
                         (fill_r >= 4'd2 && win_r[1] != HDR_FF) ||
                         (fill_r >= 4'd3 && win_r[2] != HDR_FD) ||
                         (fill_r >= 4'd4 && win_r[3] == HDR_FD) ||
                         (fill_r == WIN_DEPTH && hdr_bad);
    sts.scan_accept    = (fill_r == WIN_DEPTH);
    sts.hdr_last       = (hidx_r == 3'd7);
  end

  always_comb begin
    tmo_res            = '0;
    tmo_res.last       = 1'b1;
    tmo_res.status     = seen_r ? STAT_TMO_PART : STAT_TMO_EMPTY;
    tmo_res.servo_id   = phase_r ? pkt_id_r : 8'd0;
    tmo_res.error_code = phase_r ? pkt_err_r : 8'd0;

    body_res            = '0;
    body_res.servo_id   = pkt_id_r;
    body_res.error_code = pkt_err_r;
    if (body_end) begin
      body_res.last   = 1'b1;
      body_res.status = ({item_r.rx_byte, crc_low_r} == crc_r) ? STAT_OK : STAT_CRC_BAD;
    end else begin
      body_res.data_byte = item_r.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_id_r <= TARGET_RESET;
      max_len_r   <= MAX_LEN_RESET;
      phase_r     <= 1'b0;
      fill_r      <= '0;
      count_r     <= '0;
      total_r     <= TOTAL_RESET;
      crc_r       <= '0;
      crc_low_r   <= '0;
      pkt_id_r    <= '0;
      pkt_err_r   <= '0;
      seen_r      <= 1'b0;
      hidx_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TARGET_ID:  target_id_r <= cfg_data[7:0];
          CFG_MAX_LENGTH: max_len_r   <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid_r && !out_stall && !res_load) begin
        out_valid_r <= 1'b0;
      end

      if (cmd.load) begin
        item_r <= in_data;
      end

      if (cmd.exec_timeout) begin
        out_valid_r <= 1'b1;
        out_data_r  <= tmo_res;
        phase_r     <= 1'b0;
        fill_r      <= '0;
        seen_r      <= 1'b0;
        for (int i = 0; i < 8; i++) begin
          win_r[i] <= '0;
        end
      end

      if (cmd.exec_hunt) begin
        seen_r        <= 1'b1;
        win_r[wr_idx] <= item_r.rx_byte;
        fill_r        <= {1'b0, wr_idx} + 4'd1;
      end

      if (cmd.exec_body) begin
        seen_r <= !body_end;
        if (body_end) begin
          phase_r <= 1'b0;
          fill_r  <= '0;
          for (int i = 0; i < 8; i++) begin
            win_r[i] <= '0;
          end
          if (mine) begin
            out_valid_r <= 1'b1;
            out_data_r  <= body_res;
          end
        end else if (body_crcfield) begin
          crc_low_r <= item_r.rx_byte;
          count_r   <= count_r + 11'd1;
        end else begin
          crc_r   <= crc_item;
          count_r <= count_r + 11'd1;
          if (count_r == BODY_START) begin
            pkt_err_r <= item_r.rx_byte;
          end else if (mine) begin
            out_valid_r <= 1'b1;
            out_data_r  <= body_res;
          end
        end
      end

      if (cmd.drop) begin
        for (int i = 0; i < 7; i++) begin
          win_r[i] <= win_r[i+1];
        end
        win_r[7] <= '0;
        fill_r   <= fill_r - 4'd1;
      end

      if (cmd.hdr_start) begin
        crc_r     <= '0;
        hidx_r    <= '0;
        pkt_id_r  <= win_r[4];
        pkt_err_r <= '0;
        total_r   <= len16[10:0] + LEN_TO_TOTAL;
        count_r   <= BODY_START;
      end

      if (cmd.hdr_crc) begin
        crc_r  <= crc_byte(crc_r, win_r[hidx_r]);
        hidx_r <= hidx_r + 3'd1;
        if (hidx_r == 3'd7) begin
          phase_r <= 1'b1;
          fill_r  <= '0;
          for (int i = 0; i < 8; i++) begin
            win_r[i] <= '0;
          end
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= WIN_DEPTH) else $error("header window overfilled");

  a_body_empty_win: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> fill_r == 4'd0) else $error("window not empty in packet body");

  a_no_result_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r) else $error("stalled result dropped");

endmodule

`default_nettype wire

// ----- sv/status_packet_deframer_crc16.sv -----
// Top level of the status packet deframer with CRC-16 check.
// Input channel (in_valid/in_stall/in_data): one request per received byte
// (cmd 0) or per packet timeout (cmd 1). Result channel (out_valid/out_stall/
// out_data): parameter bytes of packets from target_id, then one end result
// with last set and the CRC status; a timeout always yields one end result.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 target_id,
// index 1 max_length; cfg_ready is always high, other indexes are ignored.
// Timing: a request is taken in the idle state and executed in the execute
// state, which loads any result into the output register; a timeout or body
// byte with a result waits there for a free output register. A hunt byte then
// goes to the header scan, which drops one byte per step (up to 8), then to the
// header CRC pass over the 8 header bytes when a header is accepted.
// A waiting result sits in the output register; the next request is still
// taken, and only a request that produces a result waits for the register.
// Reset (rst_n low, synchronous) returns to header hunting with target_id 1
// and max_length 1024; in_stall is high for the first cycle after reset.
`default_nettype none

module status_packet_deframer_crc16
  import spdc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire spdc_in_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output spdc_out_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  spdc_cmd_t cmd;
  spdc_sts_t sts;
  logic      accept;

  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  spdc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  spdc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- bench/tb_status_packet_deframer_crc16.sv -----
// Self-checking testbench: random byte/timeout requests against a packet-tracking predictor.
`timescale 1ns / 100ps

module tb_status_packet_deframer_crc16
  import spdc_pkg::*;
();

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 160;

  class deframer_tracker;
    logic [7:0]  target;
    logic [10:0] max_len;
    bit          in_body;
    logic [7:0]  win[8];
    int          fill;
    logic [10:0] count;
    logic [10:0] total;
    logic [15:0] crc;
    logic [7:0]  crc_lo;
    logic [7:0]  pid;
    logic [7:0]  perr;
    bit          seen;
    spdc_out_t   pending[$];
    int          faults;

    function new();
      target  = TARGET_RESET;
      max_len = MAX_LEN_RESET;
      count   = '0;
      total   = TOTAL_RESET;
      crc     = '0;
      crc_lo  = '0;
      pid     = '0;
      perr    = '0;
      faults  = 0;
      to_hunt();
    endfunction

    function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      bit fb;
      r = c;
      for (int i = 7; i >= 0; i--) begin
        fb = r[15] ^ b[i];
        r = {r[14:0], 1'b0};
        if (fb) begin
          r = r ^ CRC_POLY;
        end
      end
      return r;
    endfunction

    function void to_hunt();
      in_body = 0;
      fill = 0;
      foreach (win[k]) win[k] = '0;
      seen = 0;
    endfunction

    function void drop_oldest();
      if (fill == 0) return;
      for (int k = 0; k < 7; k++) win[k] = win[k+1];
      win[7] = '0;
      fill--;
    endfunction

    function void rescan();
      logic [15:0] len;
      for (int guard = 0; guard < 10; guard++) begin
        if (fill >= 1 && win[0] != HDR_FF) begin drop_oldest(); continue; end
        if (fill >= 2 && win[1] != HDR_FF) begin drop_oldest(); continue; end
        if (fill >= 3 && win[2] != HDR_FD) begin drop_oldest(); continue; end
        if (fill >= 4 && win[3] == HDR_FD) begin drop_oldest(); continue; end
        if (fill < 8) return;
        len = {win[6], win[5]};
        if (win[3] != RSVD_OK || len < MIN_LENGTH || len > {5'd0, max_len} ||
            len > MAX_PACKET || win[7] != INSTR_STATUS) begin
          drop_oldest();
          continue;
        end
        crc = '0;
        for (int k = 0; k < 8; k++) crc = crc_step(crc, win[k]);
        pid     = win[4];
        perr    = '0;
        total   = len[10:0] + LEN_TO_TOTAL;
        count   = BODY_START;
        fill    = 0;
        foreach (win[k]) win[k] = '0;
        in_body = 1;
        return;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_TARGET_ID:  target  = d[7:0];
        CFG_MAX_LENGTH: max_len = d;
        default: ;
      endcase
    endfunction

    function void take_request(spdc_in_t r);
      spdc_out_t o;
      bit mine;
      logic [15:0] got;
      o = '0;
      if (r.cmd == CMD_TIMEOUT) begin
        o.last   = 1'b1;
        o.status = seen ? STAT_TMO_PART : STAT_TMO_EMPTY;
        if (in_body) begin
          o.servo_id   = pid;
          o.error_code = (count > BODY_START) ? perr : 8'd0;
        end
        pending.push_back(o);
        to_hunt();
        return;
      end
      seen = 1;
      if (!in_body) begin
        if (fill > 7) fill = 7;
        win[fill] = r.rx_byte;
        fill++;
        rescan();
        return;
      end
      mine = (pid == target);
      if (count + 11'd1 >= total) begin
        got          = {r.rx_byte, crc_lo};
        o.last       = 1'b1;
        o.status     = (got == crc) ? STAT_OK : STAT_CRC_BAD;
        o.servo_id   = pid;
        o.error_code = perr;
        to_hunt();
        if (mine) pending.push_back(o);
        return;
      end
      if (count + 11'd2 == total) begin
        crc_lo = r.rx_byte;
        count++;
        return;
      end
      crc = crc_step(crc, r.rx_byte);
      if (count == BODY_START) begin
        perr = r.rx_byte;
        count++;
        return;
      end
      count++;
      if (mine) begin
        o.data_byte  = r.rx_byte;
        o.servo_id   = pid;
        o.error_code = perr;
        pending.push_back(o);
      end
    endfunction

    function void compare_field(string name, logic [7:0] exp, logic [7:0] act);
      if (exp !== act) begin
        $error("%s mismatch: expected %0h, got %0h", name, exp, act);
        faults++;
      end
    endfunction

    function void check_result(spdc_out_t a);
      spdc_out_t e;
      if (pending.size() == 0) begin
        $error("unexpected result: data_byte=%0h last=%0b status=%0d", a.data_byte,
               a.last, a.status);
        faults++;
        return;
      end
      e = pending.pop_front();
      compare_field("data_byte", e.data_byte, a.data_byte);
      compare_field("last", e.last, a.last);
      compare_field("status", e.status, a.status);
      compare_field("servo_id", e.servo_id, a.servo_id);
      compare_field("error_code", e.error_code, a.error_code);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  spdc_in_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  spdc_out_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  deframer_tracker trk;
  bit              calm;
  int unsigned     sent;
  logic [7:0]      cur_tid;
  logic [10:0]     cur_max;
  int              stall_left;

  status_packet_deframer_crc16 u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) trk.check_result(out_data);
      if (in_valid && !in_stall) trk.take_request(in_data);
      if (cfg_valid && cfg_ready) trk.write_reg(cfg_index, cfg_data);
    end
  end

  initial begin
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (calm) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 4);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_req(logic cmd, logic [7:0] b);
    spdc_in_t r;
    r.cmd     = cmd;
    r.rx_byte = b;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_timeout();
    send_req(CMD_TIMEOUT, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_packet(logic [7:0] id, int nparams, bit bad_crc, int cut);
    logic [7:0]  q[$];
    logic [15:0] c;
    logic [15:0] len;
    len = 16'(nparams + 4);
    q = '{HDR_FF, HDR_FF, HDR_FD, RSVD_OK, id, len[7:0], len[15:8], INSTR_STATUS};
    q.push_back(8'($urandom_range(0, 255)));
    repeat (nparams) q.push_back(8'($urandom_range(0, 255)));
    c = '0;
    foreach (q[k]) c = trk.crc_step(c, q[k]);
    if (bad_crc) c = c ^ (16'd1 << $urandom_range(0, 15));
    q.push_back(c[7:0]);
    q.push_back(c[15:8]);
    foreach (q[k]) begin
      if (k == cut) begin
        send_timeout();
        return;
      end
      send_req(CMD_BYTE, q[k]);
    end
  endtask

  task automatic send_noise();
    int n;
    int pick;
    logic [7:0] b;
    n = $urandom_range(1, 6);
    repeat (n) begin
      pick = $urandom_range(0, 4);
      case (pick)
        0: b = HDR_FF;
        1: b = HDR_FD;
        2: b = RSVD_OK;
        3: b = INSTR_STATUS;
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_req(CMD_BYTE, b);
    end
  endtask

  task automatic send_bad_header(int eff);
    logic [7:0]  h[8];
    logic [15:0] len;
    int pick;
    len  = 16'($urandom_range(4, eff));
    pick = $urandom_range(0, 4);
    h[0] = HDR_FF;
    h[1] = HDR_FF;
    h[2] = HDR_FD;
    h[3] = RSVD_OK;
    h[4] = cur_tid;
    h[7] = INSTR_STATUS;
    case (pick)
      0: h[3] = $urandom_range(0, 1) ? HDR_FD : 8'($urandom_range(1, 255));
      1: h[7] = INSTR_STATUS ^ 8'($urandom_range(1, 255));
      2: len = 16'($urandom_range(0, 3));
      3: len = $urandom_range(0, 1) ? 16'(eff + $urandom_range(1, 8))
                                     : 16'($urandom_range(eff + 1, 65535));
      default: h[$urandom_range(0, 2)] = 8'($urandom_range(0, 255));
    endcase
    h[5] = len[7:0];
    h[6] = len[15:8];
    foreach (h[k]) send_req(CMD_BYTE, h[k]);
    repeat ($urandom_range(0, 3)) send_req(CMD_BYTE, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 1)) send_timeout();
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (trk.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_one(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic program_regs(logic [CFG_DATA_W-1:0] tid, logic [CFG_DATA_W-1:0] mlen,
                              bit spare);
    settle();
    write_one(CFG_TARGET_ID, tid);
    write_one(CFG_MAX_LENGTH, mlen);
    if (spare) write_one(CFG_IDX_SPARE, CFG_DATA_W'($urandom_range(0, 2047)));
    cfg_valid <= 1'b0;
    cur_tid = tid[7:0];
    cur_max = mlen;
  endtask

  task automatic run_phase(int items);
    int unsigned stop;
    int kind;
    int eff;
    int np;
    int r;
    logic [7:0] id;
    stop = sent + items;
    eff  = (cur_max > MAX_PACKET) ? MAX_PACKET : int'(cur_max);
    while (sent < stop) begin
      kind = $urandom_range(0, 19);
      id   = ($urandom_range(0, 3) != 0) ? cur_tid : 8'($urandom_range(0, 255));
      if (kind < 12) begin
        r  = $urandom_range(0, 19);
        np = (r < 15) ? $urandom_range(0, 6) : (r < 19) ? $urandom_range(0, 40)
                                                       : $urandom_range(0, 200);
        if (np > eff - 4) np = eff - 4;
        send_packet(id, np, $urandom_range(0, 4) == 0,
                    ($urandom_range(0, 9) == 0) ? $urandom_range(0, np + 10) : -1);
      end else if (kind < 14) begin
        np = $urandom_range(0, 1) ? eff - 4 : $urandom_range(0, eff - 4);
        send_packet(id, np, 1'b0, $urandom_range(8, 20));
      end else if (kind < 16) begin
        send_bad_header(eff);
      end else if (kind < 18) begin
        send_noise();
      end else begin
        send_timeout();
      end
    end
  endtask

  initial begin
    logic [7:0] short_hdr[8];
    trk       = new();
    calm      = 0;
    sent      = 0;
    cur_tid   = TARGET_RESET;
    cur_max   = MAX_LEN_RESET;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    short_hdr = '{HDR_FF, HDR_FF, HDR_FD, RSVD_OK, TARGET_RESET, 8'd3, 8'd0, INSTR_STATUS};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty timeout, stray byte, minimal good packet, length-3 header, partial timeout
    send_timeout();
    send_req(CMD_BYTE, 8'h00);
    send_packet(TARGET_RESET, 0, 1'b0, -1);
    foreach (short_hdr[k]) send_req(CMD_BYTE, short_hdr[k]);
    send_timeout();

    run_phase(PHASE_ITEMS);
    program_regs(11'd0, 11'd4, 1'b0);
    run_phase(PHASE_ITEMS);
    program_regs(11'h7FF, 11'h7FF, 1'b1);
    run_phase(PHASE_ITEMS);
    program_regs(CFG_DATA_W'($urandom_range(0, 2047)), CFG_DATA_W'($urandom_range(5, 40)),
                 1'b0);
    run_phase(PHASE_ITEMS);
    program_regs(TARGET_RESET, MAX_LEN_RESET, 1'b1);
    run_phase(PHASE_ITEMS);
    program_regs(CFG_DATA_W'($urandom_range(0, 255)), CFG_DATA_W'($urandom_range(4, 1024)),
                 1'b0);
    calm = 1;
    run_phase(PHASE_ITEMS);
    settle();

    if (trk.pending.size() != 0) $error("%0d results never arrived", trk.pending.size());
    if (trk.faults == 0 && trk.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/spdc_pkg.sv
sv/spdc_ctrl.sv
sv/spdc_dp.sv
sv/status_packet_deframer_crc16.sv
bench/tb_status_packet_deframer_crc16.sv
